### rtl/covering_design_checker_assert.svh
// Assertion shorthands for the covering design checker.
// Both sample on clk and are off while rst is high.
`ifndef COVERING_DESIGN_CHECKER_ASSERT_SVH
`define COVERING_DESIGN_CHECKER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CDC_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("covering design checker assertion failed");

// consequent holds in the cycle after the antecedent
`define CDC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("covering design checker assertion failed");

`endif

### rtl/cdc_pkg.sv
package cdc_pkg;

  localparam int MAX_BLOCKS    = 512;
  localparam int ELEMENT_RANGE = 32;

  localparam int NUM_ELEMS = 6;
  localparam int ELEM_W    = 5;
  localparam int SIZE_W    = 3;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int FIRST_W   = 9;
  localparam int COUNT_W   = 10;

  // lane count must be a power of two
  localparam int LANES    = 4;
  localparam int LANE_W   = $clog2(LANES);
  localparam int ROWS     = (MAX_BLOCKS + LANES - 1) / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROWCNT_W = $clog2(ROWS + 1);
  localparam int TOTAL_W  = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W    = ROW_W + LANE_W;
  localparam int CMP_W    = (IDX_W + 1 > TOTAL_W) ? IDX_W + 1 : TOTAL_W;

  localparam int MASK_W = ELEMENT_RANGE;
  localparam int MIDX_W = $clog2(ELEMENT_RANGE);
  localparam int RNG_W  = 8;
  localparam int CNT_W  = $clog2(NUM_ELEMS + 1);

  localparam int IN_FIELDS_W  = NUM_ELEMS * ELEM_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int USER_W       = CMD_W;
  localparam int OUT_FIELDS_W = 1 + FIRST_W + COUNT_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_COVERED_BIT = 0;
  localparam int OUT_FIRST_LO    = 1;
  localparam int OUT_COUNT_LO    = OUT_FIRST_LO + FIRST_W;
  localparam int OUT_OVF_BIT     = OUT_COUNT_LO + COUNT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBSET_SIZE = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [NUM_ELEMS-1:0] elem_vec_t;
  typedef logic [MASK_W-1:0] mask_t;

  // subset as a list of elements; pick marks first in-range occurrences
  typedef struct packed {
    logic [NUM_ELEMS-1:0] pick;
    elem_vec_t            elem;
  } query_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } merge_t;

  function automatic logic in_range(input elem_t e);
    return RNG_W'(e) < RNG_W'(ELEMENT_RANGE);
  endfunction

  function automatic mask_t build_mask(input elem_vec_t e, input logic [SIZE_W-1:0] size);
    mask_t m;
    m = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (i < int'(size) && in_range(e[i])) begin
        m[MIDX_W'(e[i])] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic query_t build_query(input elem_vec_t e, input logic [SIZE_W-1:0] size);
    query_t q;
    logic   dup;
    q.elem = e;
    q.pick = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      dup = 1'b0;
      for (int j = 0; j < i; j++) begin
        if (e[j] == e[i]) begin
          dup = 1'b1;
        end
      end
      q.pick[i] = (i < int'(size)) && in_range(e[i]) && !dup;
    end
    return q;
  endfunction

endpackage

### rtl/cdc_ram.sv
module cdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cdc_lane.sv
module cdc_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  cdc_pkg::mask_t            mask,
  input  cdc_pkg::query_t           query,
  input  logic [cdc_pkg::SIZE_W-1:0] threshold,
  output logic                      hit
);
  import cdc_pkg::*;

  logic [CNT_W-1:0] shared;

  always_comb begin
    shared = '0;
    for (int i = 0; i < NUM_ELEMS; i++) begin
      if (query.pick[i] && mask[MIDX_W'(query.elem[i])]) begin
        shared = shared + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else begin
      hit <= en && ((SIZE_W + CNT_W)'(shared) >= (SIZE_W + CNT_W)'(threshold));
    end
  end

endmodule

### rtl/cdc_merge.sv
module cdc_merge (
  input  logic                       valid,
  input  logic [cdc_pkg::LANES-1:0] hits,
  output cdc_pkg::merge_t            result
);
  import cdc_pkg::*;

  // lowest lane holds the lowest block index of the row
  always_comb begin
    result.hit  = 1'b0;
    result.lane = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (valid && hits[k]) begin
        result.hit  = 1'b1;
        result.lane = LANE_W'(k);
      end
    end
  end

endmodule

### rtl/covering_design_checker.sv
// Covering design checker: a store of blocks, each held as an element
// membership mask, checked against query subsets.
// s_axis: one command item; tuser carries the command (load, query, clear),
// tdata the six 5-bit element numbers. m_axis: one result item per command.
// cfg: register writes (subset size, block size, threshold), always ready.
// Blocks sit in four memory banks, block b in bank b mod 4 at row b / 4.
// A query reads one row per cycle from all banks; four lanes count shared
// elements and a merge stage picks the lowest covering block of the row.
// A query steps its row address through the bank read register and the lane
// hit register into the merge stage, and stops at the first covering row or
// after the last stored row; load and clear go straight to the result. A new
// item is taken once the previous one has moved into the output register.
// Reset empties the store and loads the register defaults; block contents
// are not cleared. A stalled receiver holds the result in the output
// register; the next item is accepted meanwhile and waits to deliver.
module covering_design_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, zero fill
  input  logic [cdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [cdc_pkg::USER_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // covered, first_block, stored_blocks, overflow, zero fill
  output logic [cdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdc_pkg::SIZE_W-1:0]     cfg_data
);
  import cdc_pkg::*;

  state_t              state, state_next;
  logic [SIZE_W-1:0]   subset_size, block_size, threshold;
  logic [TOTAL_W-1:0]  total;
  query_t              query;
  logic [ROWCNT_W-1:0] scan_rows, issue_row, rows_calc;
  logic                v1, v2;
  logic [ROW_W-1:0]    r1, r2;
  logic                res_covered, res_overflow;
  logic [FIRST_W-1:0]  res_first;

  logic                accept, full, load_we, issue, scan_hit, scan_miss, out_load;
  cmd_t                cmd;
  elem_vec_t           elems;
  mask_t               load_mask;
  mask_t               rd_mask [LANES];
  logic [LANES-1:0]    lane_hit;
  merge_t              merged;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign cmd       = cmd_t'(s_axis_tuser);
  assign elems     = elem_vec_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
  assign full      = total == TOTAL_W'(MAX_BLOCKS);
  assign load_mask = build_mask(elems, block_size);
  assign rows_calc = ROWCNT_W'(((TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(LANES - 1)) >> LANE_W);

  always_comb begin
    s_axis_tready = state == ST_IDLE;
    load_we       = accept && cmd == CMD_LOAD && !full;
    issue         = state == ST_SCAN && issue_row != scan_rows && !merged.hit;
    scan_hit      = merged.hit;
    scan_miss     = state == ST_SCAN && issue_row == scan_rows && !v1 && !v2;
    out_load      = state == ST_DONE && (!m_axis_tvalid || m_axis_tready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (cmd == CMD_QUERY) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_hit || scan_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic lane_en;

    assign lane_en = v1 && (CMP_W'({r1, LANE_W'(k)}) < CMP_W'(total));

    cdc_ram #(
      .WIDTH(MASK_W),
      .DEPTH(ROWS)
    ) u_bank (
      .clk  (clk),
      .we   (load_we && total[LANE_W-1:0] == LANE_W'(k)),
      .waddr(ROW_W'(total >> LANE_W)),
      .wdata(load_mask),
      .raddr(issue_row[ROW_W-1:0]),
      .rdata(rd_mask[k])
    );

    cdc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (lane_en),
      .mask     (rd_mask[k]),
      .query    (query),
      .threshold(threshold),
      .hit      (lane_hit[k])
    );
  end

  cdc_merge u_merge (
    .valid (v2 && state == ST_SCAN),
    .hits  (lane_hit),
    .result(merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      subset_size   <= SIZE_W'(4);
      block_size    <= SIZE_W'(6);
      threshold     <= SIZE_W'(3);
      total         <= '0;
      issue_row     <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SUBSET_SIZE: subset_size <= cfg_data;
          CFG_BLOCK_SIZE:  block_size  <= cfg_data;
          CFG_THRESHOLD:   threshold   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        unique case (cmd)
          CMD_LOAD:  if (!full) total <= total + TOTAL_W'(1);
          CMD_QUERY: issue_row <= '0;
          CMD_CLEAR: total <= '0;
          default: ;
        endcase
      end else if (issue) begin
        issue_row <= issue_row + ROWCNT_W'(1);
      end
      v1 <= issue;
      v2 <= state == ST_SCAN && v1 && !scan_hit;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r1 <= issue_row[ROW_W-1:0];
    r2 <= r1;
    if (accept) begin
      query        <= build_query(elems, subset_size);
      scan_rows    <= rows_calc;
      res_covered  <= 1'b0;
      res_first    <= '0;
      res_overflow <= cmd == CMD_LOAD && full;
    end
    if (state == ST_SCAN && scan_hit) begin
      res_covered <= 1'b1;
      res_first   <= FIRST_W'({r2, merged.lane});
    end
    if (out_load) begin
      m_axis_tdata <= OUT_DATA_W'({res_overflow, COUNT_W'(total), res_first, res_covered});
    end
  end

endmodule

### rtl/cdc_checker.sv
`include "covering_design_checker_assert.svh"

module cdc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cdc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cdc_pkg::*;

  // one item in work at a time
  `CDC_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a block index is only reported with a covering result
  `CDC_ASSERT_SAME(a_first_needs_cover, m_axis_tvalid && !m_axis_tdata[OUT_COVERED_BIT], m_axis_tdata[OUT_COUNT_LO-1:OUT_FIRST_LO] == '0)
  `CDC_ASSERT_SAME(a_cover_no_overflow, m_axis_tvalid && m_axis_tdata[OUT_COVERED_BIT], !m_axis_tdata[OUT_OVF_BIT])
  `CDC_ASSERT_SAME(a_count_bound, m_axis_tvalid, m_axis_tdata[OUT_OVF_BIT-1:OUT_COUNT_LO] <= COUNT_W'(MAX_BLOCKS))

endmodule

bind covering_design_checker cdc_checker u_cdc_checker (.*);
